[sv/wsm_pkg.sv]
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, codes and helpers for the wildcard star matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;
  localparam int DATA_W = 32;
  localparam int CFG_AW = 3;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'd42;

  // input action field
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_NAME = 1'b1;

  // configuration register index
  localparam logic REG_LEN  = 1'b0;
  localparam logic REG_CASE = 1'b1;

  // queued item kind
  localparam logic [1:0] K_LOAD = 2'd0;
  localparam logic [1:0] K_CHAR = 2'd1;
  localparam logic [1:0] K_LAST = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] chr;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic             case_sensitive;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic              cs);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!cs && c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

[sv/wsm_front.sv]
// ----------------------------------------------------------------------------
// wsm_front
// Takes input beats, sorts them into pattern loads and name characters,
// drops out-of-store loads and folds name characters before queuing.
// ----------------------------------------------------------------------------
module wsm_front
  import wsm_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [IDX_W-1:0]  in_pattern_index,
  input  logic [CHAR_W-1:0] in_char_value,
  input  logic              in_last,
  input  logic              case_sensitive,
  input  logic              q_full,
  output logic              push,
  output item_t             item
);

  logic accept;
  logic in_range;

  always_comb begin
    in_ready = !q_full;
    accept   = in_valid && !q_full;
    in_range = int'(in_pattern_index) < MAX_PATTERN;
    item.idx = in_pattern_index;
    if (in_action == ACT_NAME) begin
      item.kind = in_last ? K_LAST : K_CHAR;
      item.chr  = fold_char(in_char_value, case_sensitive);
      push      = accept;
    end else begin
      item.kind = K_LOAD;
      item.chr  = in_char_value;
      push      = accept && in_range;
    end
  end

endmodule

[sv/wsm_queue.sv]
// ----------------------------------------------------------------------------
// wsm_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module wsm_queue
  import wsm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t          slot_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  always_comb begin
    full    = cnt_r == (QAW+1)'(QDEPTH);
    valid   = cnt_r != '0;
    head    = slot_r[rp_r];
    do_push = push && !full;
    do_pop  = pop && valid;
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

[sv/wsm_back.sv]
// ----------------------------------------------------------------------------
// wsm_back
// Pattern store and match sequencer: one store read per cycle, greedy star
// matching with a cached rewind target, final trailing-star walk.
// ----------------------------------------------------------------------------
module wsm_back
  import wsm_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  cfg_wr,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_matched
);

  localparam int PW  = $clog2(MAX_PATTERN);
  localparam int PLW = $clog2(MAX_PATTERN + 1);

  localparam logic [1:0] PH_A = 2'd0;   // compare at pattern_pos
  localparam logic [1:0] PH_W = 2'd1;   // walk a star run
  localparam logic [1:0] PH_F = 2'd2;   // final trailing-star check

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [CHAR_W-1:0] mem [MAX_PATTERN];
  logic [CHAR_W-1:0] rdata_r;

  logic [PLW-1:0]    pp_r, pp_nxt, sp_r, sp_nxt, w_r, w_nxt, cq_r, cq_nxt;
  logic [PLW-1:0]    len_eff, pos_cur, pos_nxt;
  logic              sv_r, sv_nxt, cv_r, cv_nxt;
  logic [CHAR_W-1:0] cchar_r, cchar_nxt;
  logic [1:0]        st_r, st_nxt, ph_r, ph_nxt;
  logic              out_valid_r, out_valid_nxt, out_matched_r, out_matched_nxt;
  logic              emit, verdict, pop_raw, char_done, adv, out_free, mem_we;
  logic [CHAR_W-1:0] bf, cf;
  logic [IDX_W+PW-1:0] idx_ext;
  logic [PW-1:0]     waddr, rd_addr;

  always_comb begin
    if (int'(cfg.pattern_length) > MAX_PATTERN) begin
      len_eff = PLW'(MAX_PATTERN);
    end else begin
      len_eff = PLW'(cfg.pattern_length);
    end
    bf      = fold_char(rdata_r, cfg.case_sensitive);
    cf      = fold_char(cchar_r, cfg.case_sensitive);
    idx_ext = {{PW{1'b0}}, q_item.idx};
    waddr   = idx_ext[PW-1:0];
    out_free = !out_valid_r || out_ready;

    pp_nxt    = pp_r;
    sp_nxt    = sp_r;
    w_nxt     = w_r;
    sv_nxt    = sv_r;
    cv_nxt    = cv_r;
    cq_nxt    = cq_r;
    cchar_nxt = cchar_r;
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    emit      = 1'b0;
    verdict   = 1'b0;
    pop_raw   = 1'b0;
    char_done = 1'b0;
    mem_we    = 1'b0;

    if (q_valid) begin
      case (q_item.kind)
        K_LOAD: begin
          mem_we  = 1'b1;
          cv_nxt  = 1'b0;
          pop_raw = 1'b1;
        end
        K_CHAR, K_LAST: begin
          if (st_r != ST_RUN) begin
            char_done = 1'b1;
          end else begin
            case (ph_r)
              PH_A: begin
                if (pp_r >= len_eff) begin
                  st_nxt    = ST_FAIL;
                  char_done = 1'b1;
                end else if (rdata_r == STAR_CHAR) begin
                  sp_nxt = pp_r;
                  sv_nxt = 1'b1;
                  cv_nxt = 1'b0;
                  w_nxt  = pp_r + PLW'(1);
                  ph_nxt = PH_W;
                end else if (bf == q_item.chr) begin
                  pp_nxt    = pp_r + PLW'(1);
                  char_done = 1'b1;
                end else if (sv_r) begin
                  if (cv_r) begin
                    pp_nxt    = (cf == q_item.chr) ? cq_r + PLW'(1) : cq_r;
                    char_done = 1'b1;
                  end else begin
                    sv_nxt = 1'b0;
                    pp_nxt = sp_r;
                  end
                end else begin
                  st_nxt    = ST_FAIL;
                  char_done = 1'b1;
                end
              end
              PH_W: begin
                if (w_r >= len_eff) begin
                  st_nxt    = ST_ACC;
                  pp_nxt    = w_r;
                  char_done = 1'b1;
                end else if (rdata_r == STAR_CHAR) begin
                  w_nxt = w_r + PLW'(1);
                end else begin
                  cv_nxt    = 1'b1;
                  cq_nxt    = w_r;
                  cchar_nxt = rdata_r;
                  pp_nxt    = (bf == q_item.chr) ? w_r + PLW'(1) : w_r;
                  char_done = 1'b1;
                end
              end
              PH_F: begin
                if (w_r >= len_eff) begin
                  emit    = 1'b1;
                  verdict = 1'b1;
                end else if (rdata_r == STAR_CHAR) begin
                  w_nxt = w_r + PLW'(1);
                end else begin
                  emit    = 1'b1;
                  verdict = 1'b0;
                end
              end
              default: begin
                ph_nxt = PH_A;
              end
            endcase
          end
          if (char_done) begin
            ph_nxt = PH_A;
            if (q_item.kind == K_LAST) begin
              if (st_nxt == ST_ACC) begin
                emit    = 1'b1;
                verdict = 1'b1;
              end else if (st_nxt == ST_FAIL) begin
                emit    = 1'b1;
                verdict = 1'b0;
              end else if (pp_nxt >= len_eff) begin
                emit    = 1'b1;
                verdict = 1'b1;
              end else begin
                ph_nxt = PH_F;
                w_nxt  = pp_nxt;
              end
            end else begin
              pop_raw = 1'b1;
            end
          end
        end
        default: begin
          pop_raw = 1'b1;
        end
      endcase
    end

    adv             = !(emit && !out_free);
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    if (emit && adv) begin
      pop_raw         = 1'b1;
      pp_nxt          = '0;
      sp_nxt          = '0;
      sv_nxt          = 1'b0;
      cv_nxt          = 1'b0;
      st_nxt          = ST_RUN;
      ph_nxt          = PH_A;
      out_valid_nxt   = 1'b1;
      out_matched_nxt = verdict;
    end
    if (cfg_wr) begin
      cv_nxt = 1'b0;
    end

    q_pop   = pop_raw && adv;
    pos_cur = (ph_r == PH_A) ? pp_r : w_r;
    pos_nxt = (ph_nxt == PH_A) ? pp_nxt : w_nxt;
    rd_addr = adv ? pos_nxt[PW-1:0] : pos_cur[PW-1:0];
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r        <= '0;
      sp_r        <= '0;
      w_r         <= '0;
      sv_r        <= 1'b0;
      cv_r        <= 1'b0;
      st_r        <= ST_RUN;
      ph_r        <= PH_A;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        pp_r <= pp_nxt;
        sp_r <= sp_nxt;
        w_r  <= w_nxt;
        sv_r <= sv_nxt;
        cv_r <= cv_nxt;
        st_r <= st_nxt;
        ph_r <= ph_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cq_r    <= cq_nxt;
      cchar_r <= cchar_nxt;
    end
    out_matched_r <= out_matched_nxt;
  end

  // pattern store, read every cycle at the next position, write bypassed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_item.chr;
    end
    if (mem_we && waddr == rd_addr) begin
      rdata_r <= q_item.chr;
    end else begin
      rdata_r <= mem[rd_addr];
    end
  end

  a_walk_running: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_A) |-> (st_r == ST_RUN))
    else $error("walk phase with name already settled");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pp_r <= PLW'(MAX_PATTERN)) && (w_r <= PLW'(MAX_PATTERN)))
    else $error("pattern position beyond store");

  a_cache_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r |-> (sv_r && (cq_r > sp_r)))
    else $error("rewind cache without live star");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == K_LOAD) |-> (ph_r == PH_A))
    else $error("load taken in the middle of a character");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == K_LAST) |=> out_valid_r)
    else $error("last character retired without a result");

endmodule

[sv/wildcard_star_matcher.sv]
// ----------------------------------------------------------------------------
// wildcard_star_matcher
// Streams name characters against a stored pattern where '*' matches any run.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   in      | in_valid/in_ready   | in_action in_pattern_index in_char_value in_last
//   out     | out_valid/out_ready | out_matched
//   config  | psel/penable/pready | paddr pwrite pwdata prdata
//
// Loads and plainly matching name characters take one store read each, limited
// by the single read port of the pattern store. Reaching a star run walks its
// stars one at a time; a rewind to an unwalked star returns to it and walks
// the run. A last character walks any trailing stars unless the pattern is
// already used up. Synchronous reset; no clearing pass. A four-entry queue and
// an output register let input and output stall apart.
// ----------------------------------------------------------------------------
module wildcard_star_matcher
  import wsm_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [IDX_W-1:0]  in_pattern_index,
  input  logic [CHAR_W-1:0] in_char_value,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             cs_r, cs_nxt;
  logic             cfg_wr;
  logic             reg_idx;
  cfg_t             cfg;

  logic  push, q_full, q_valid, q_pop;
  item_t push_item, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1];

  always_comb begin
    cfg_wr  = psel && penable && pwrite && pready;
    len_nxt = len_r;
    cs_nxt  = cs_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_LEN:  len_nxt = pwdata[LEN_W-1:0];
        REG_CASE: cs_nxt  = pwdata[0];
        default:  len_nxt = len_r;
      endcase
    end
    case (reg_idx)
      REG_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, len_r};
      REG_CASE: prdata = {{(DATA_W-1){1'b0}}, cs_r};
      default:  prdata = '0;
    endcase
    cfg.pattern_length = len_r;
    cfg.case_sensitive = cs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cs_r  <= 1'b0;
    end else begin
      len_r <= len_nxt;
      cs_r  <= cs_nxt;
    end
  end

  wsm_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_pattern_index (in_pattern_index),
    .in_char_value    (in_char_value),
    .in_last          (in_last),
    .case_sensitive   (cs_r),
    .q_full           (q_full),
    .push             (push),
    .item             (push_item)
  );

  wsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  wsm_back #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cfg_wr      (cfg_wr),
    .q_valid     (q_valid),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_matched (out_matched)
  );

endmodule
